// File: rtl/core/svwp_pkg.sv
// ----------------------------------------------------------------------------
// svwp_pkg
// Shared types and constants of the supply voltage window protector.
// ----------------------------------------------------------------------------
package svwp_pkg;

  localparam int unsigned CODE_W = 12;
  localparam int unsigned RUN_W  = 4;
  localparam int unsigned IDX_W  = 3;

  localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

  // reset values, codes = volts * 4096 / 5 rounded
  localparam logic [CODE_W-1:0] HIGH_TRIP_RST    = 12'd1352;
  localparam logic [CODE_W-1:0] LOW_TRIP_RST     = 12'd696;
  localparam logic [CODE_W-1:0] HIGH_RESTART_RST = 12'd1311;
  localparam logic [CODE_W-1:0] LOW_RESTART_RST  = 12'd737;
  localparam logic [RUN_W-1:0]  CONFIRM_RST      = 4'd3;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_OFF_HIGH = 2'd1,
    MODE_OFF_LOW  = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_CUT_HIGH     = 3'd1,
    EV_CUT_LOW      = 3'd2,
    EV_RESTART_HIGH = 3'd3,
    EV_RESTART_LOW  = 3'd4
  } event_e;

  typedef enum logic [IDX_W-1:0] {
    REG_HIGH_TRIP     = 3'd0,
    REG_LOW_TRIP      = 3'd1,
    REG_HIGH_RESTART  = 3'd2,
    REG_LOW_RESTART   = 3'd3,
    REG_CONFIRM_COUNT = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [CODE_W-1:0] high_trip;
    logic [CODE_W-1:0] low_trip;
    logic [CODE_W-1:0] high_restart;
    logic [CODE_W-1:0] low_restart;
    logic [RUN_W-1:0]  confirm_count;
  } cfg_t;

  typedef struct packed {
    logic   power_enable;
    mode_e  mode;
    event_e event_res;
  } res_t;

endpackage

// File: rtl/core/svwp_sample_if.sv
// ----------------------------------------------------------------------------
// svwp_sample_if
// Sample channel: one converter sample per transaction.
// ----------------------------------------------------------------------------
interface svwp_sample_if;
  logic                       valid;
  logic                       ready;
  logic [svwp_pkg::CODE_W-1:0] sample_code;
  logic                       sample_valid;

  modport source (output valid, output sample_code, output sample_valid, input ready);
  modport sink   (input valid, input sample_code, input sample_valid, output ready);
endinterface

// File: rtl/core/svwp_result_if.sv
// ----------------------------------------------------------------------------
// svwp_result_if
// Result channel: power state and event for each sample.
// ----------------------------------------------------------------------------
interface svwp_result_if;
  logic             valid;
  logic             ready;
  logic             power_enable;
  svwp_pkg::mode_e  mode;
  svwp_pkg::event_e event_res;

  modport source (output valid, output power_enable, output mode, output event_res,
                  input ready);
  modport sink   (input valid, input power_enable, input mode, input event_res,
                  output ready);
endinterface

// File: rtl/core/svwp_cfg_if.sv
// ----------------------------------------------------------------------------
// svwp_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface svwp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [svwp_pkg::IDX_W-1:0]  index;
  logic [svwp_pkg::CODE_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/svwp_cfg_regs.sv
// ----------------------------------------------------------------------------
// svwp_cfg_regs
// Threshold and confirm count registers, written over the config channel.
// ----------------------------------------------------------------------------
module svwp_cfg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  svwp_cfg_if.sink          cfg_i,
  output svwp_pkg::cfg_t    cfg_o
);

  svwp_pkg::cfg_t cfg_d, cfg_q;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        svwp_pkg::REG_HIGH_TRIP:     cfg_d.high_trip     = cfg_i.data;
        svwp_pkg::REG_LOW_TRIP:      cfg_d.low_trip      = cfg_i.data;
        svwp_pkg::REG_HIGH_RESTART:  cfg_d.high_restart  = cfg_i.data;
        svwp_pkg::REG_LOW_RESTART:   cfg_d.low_restart   = cfg_i.data;
        svwp_pkg::REG_CONFIRM_COUNT: cfg_d.confirm_count = cfg_i.data[svwp_pkg::RUN_W-1:0];
        default:                     cfg_d = cfg_q;  // unused index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_trip     <= svwp_pkg::HIGH_TRIP_RST;
      cfg_q.low_trip      <= svwp_pkg::LOW_TRIP_RST;
      cfg_q.high_restart  <= svwp_pkg::HIGH_RESTART_RST;
      cfg_q.low_restart   <= svwp_pkg::LOW_RESTART_RST;
      cfg_q.confirm_count <= svwp_pkg::CONFIRM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/svwp_core.sv
// ----------------------------------------------------------------------------
// svwp_core
// Protection mode and run counters, updated once per stepped sample.
// ----------------------------------------------------------------------------
module svwp_core #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  svwp_pkg::cfg_t              cfg_i,
  input  logic                        step_i,
  input  logic [svwp_pkg::CODE_W-1:0] code_i,
  input  logic                        flag_i,
  output svwp_pkg::res_t              res_o
);

  localparam int unsigned CmpBits =
    (SAMPLE_BITS < svwp_pkg::CODE_W) ? SAMPLE_BITS : svwp_pkg::CODE_W;

  svwp_pkg::mode_e                mode_d, mode_q;
  logic [svwp_pkg::RUN_W-1:0]     above_d, above_q;
  logic [svwp_pkg::RUN_W-1:0]     below_d, below_q;
  logic [svwp_pkg::RUN_W-1:0]     need;
  svwp_pkg::event_e               ev;
  logic [CmpBits-1:0]             code;
  logic                           hit_high_trip, hit_low_trip;
  logic                           hit_high_restart, hit_low_restart;

  function automatic logic [svwp_pkg::RUN_W-1:0] bump(
    input logic [svwp_pkg::RUN_W-1:0] run,
    input logic                       hit
  );
    logic [svwp_pkg::RUN_W-1:0] r;
    if (!hit) begin
      r = '0;
    end else if (run == svwp_pkg::RUN_MAX) begin
      r = svwp_pkg::RUN_MAX;
    end else begin
      r = run + 1'b1;
    end
    return r;
  endfunction

  // zero confirm count behaves as one
  assign need = (cfg_i.confirm_count == '0) ? svwp_pkg::RUN_W'(1) : cfg_i.confirm_count;

  assign code             = code_i[CmpBits-1:0];
  assign hit_high_trip    = code >= cfg_i.high_trip[CmpBits-1:0];
  assign hit_low_trip     = code <= cfg_i.low_trip[CmpBits-1:0];
  assign hit_high_restart = code <= cfg_i.high_restart[CmpBits-1:0];
  assign hit_low_restart  = code >= cfg_i.low_restart[CmpBits-1:0];

  always_comb begin
    mode_d  = mode_q;
    above_d = above_q;
    below_d = below_q;
    ev      = svwp_pkg::EV_NONE;
    if (flag_i) begin
      unique case (mode_q)
        svwp_pkg::MODE_OFF_HIGH: begin
          below_d = bump(below_q, hit_high_restart);
          above_d = '0;
          if (below_d >= need) begin
            mode_d  = svwp_pkg::MODE_NORMAL;
            ev      = svwp_pkg::EV_RESTART_HIGH;
            below_d = '0;
          end
        end
        svwp_pkg::MODE_OFF_LOW: begin
          above_d = bump(above_q, hit_low_restart);
          below_d = '0;
          if (above_d >= need) begin
            mode_d  = svwp_pkg::MODE_NORMAL;
            ev      = svwp_pkg::EV_RESTART_LOW;
            above_d = '0;
          end
        end
        default: begin
          // normal mode, over-voltage check first
          mode_d  = svwp_pkg::MODE_NORMAL;
          above_d = bump(above_q, hit_high_trip);
          below_d = bump(below_q, hit_low_trip);
          if (above_d >= need) begin
            mode_d  = svwp_pkg::MODE_OFF_HIGH;
            ev      = svwp_pkg::EV_CUT_HIGH;
            above_d = '0;
            below_d = '0;
          end else if (below_d >= need) begin
            mode_d  = svwp_pkg::MODE_OFF_LOW;
            ev      = svwp_pkg::EV_CUT_LOW;
            above_d = '0;
            below_d = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= svwp_pkg::MODE_NORMAL;
      above_q <= '0;
      below_q <= '0;
    end else if (step_i) begin
      mode_q  <= mode_d;
      above_q <= above_d;
      below_q <= below_d;
    end
  end

  always_comb begin
    res_o.power_enable = (mode_d == svwp_pkg::MODE_NORMAL);
    res_o.mode         = mode_d;
    res_o.event_res    = ev;
  end

endmodule

// File: rtl/core/supply_voltage_window_protector.sv
// ----------------------------------------------------------------------------
// supply_voltage_window_protector
// Over/under-voltage power cut-off with hysteresis on raw converter codes.
// ----------------------------------------------------------------------------
// a sample is held in the input register, then its result in the output register
// throughput: one sample per cycle while the result channel is not stalled
// while a finished result is stalled, the input register takes a new sample only if it is empty
// reset: power on in normal mode, run counters zero, thresholds at defaults,
// both pipeline registers empty
module supply_voltage_window_protector #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  svwp_sample_if.sink   sample_i,
  svwp_result_if.source result_o,
  svwp_cfg_if.sink      cfg_i
);

  svwp_pkg::cfg_t              cfg;
  svwp_pkg::res_t              res;
  svwp_pkg::res_t              out_res_q;
  logic                        in_vld_d, in_vld_q;
  logic [svwp_pkg::CODE_W-1:0] in_code_q;
  logic                        in_flag_q;
  logic                        out_vld_d, out_vld_q;
  logic                        out_adv;
  logic                        in_adv;
  logic                        in_acc;

  svwp_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  assign out_adv        = !out_vld_q || result_o.ready;
  assign in_adv         = in_vld_q && out_adv;
  assign sample_i.ready = !in_vld_q || out_adv;
  assign in_acc         = sample_i.valid && sample_i.ready;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (in_adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (in_adv) begin
      out_vld_d = 1'b1;
    end else if (result_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_code_q <= sample_i.sample_code;
      in_flag_q <= sample_i.sample_valid;
    end
    if (in_adv) begin
      out_res_q <= res;
    end
  end

  svwp_core #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (in_adv),
    .code_i (in_code_q),
    .flag_i (in_flag_q),
    .res_o  (res)
  );

  assign result_o.valid        = out_vld_q;
  assign result_o.power_enable = out_res_q.power_enable;
  assign result_o.mode         = out_res_q.mode;
  assign result_o.event_res    = out_res_q.event_res;

endmodule

// File: rtl/core/svwp_checker.sv
// ----------------------------------------------------------------------------
// svwp_checker
// Port-level checks of the supply voltage window protector.
// ----------------------------------------------------------------------------
module svwp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       power_enable_i,
  input logic [1:0] mode_i,
  input logic [2:0] event_res_i
);

  // power switch follows the mode
  a_power_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (power_enable_i == (mode_i == svwp_pkg::MODE_NORMAL)))
    else $error("power_enable does not match mode");

  // an event always lands in the mode it leads to
  a_event_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      ((event_res_i == svwp_pkg::EV_NONE) ||
       ((event_res_i == svwp_pkg::EV_CUT_HIGH) && (mode_i == svwp_pkg::MODE_OFF_HIGH)) ||
       ((event_res_i == svwp_pkg::EV_CUT_LOW) && (mode_i == svwp_pkg::MODE_OFF_LOW)) ||
       ((event_res_i == svwp_pkg::EV_RESTART_HIGH) && (mode_i == svwp_pkg::MODE_NORMAL)) ||
       ((event_res_i == svwp_pkg::EV_RESTART_LOW) && (mode_i == svwp_pkg::MODE_NORMAL))))
    else $error("event_res inconsistent with mode");

  // input side only stalls behind a stalled result
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i))
    else $error("sample channel stalled without output backpressure");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(power_enable_i) && $stable(mode_i) && $stable(event_res_i)))
    else $error("stalled result changed");

  // no input transaction may vanish: a sample taken while no result is pending yields a valid result
  a_in_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && !out_valid_i) |=> ##1 out_valid_i)
    else $error("accepted sample produced no result");

endmodule

bind supply_voltage_window_protector svwp_checker u_svwp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (result_o.valid),
  .out_ready_i    (result_o.ready),
  .power_enable_i (result_o.power_enable),
  .mode_i         (result_o.mode),
  .event_res_i    (result_o.event_res)
);

// File: tb/sv/supply_voltage_window_protector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// supply_voltage_window_protector_tb
// Drives sample transactions through the protector under changing thresholds
// and confirm counts, predicts mode and events per sample, and compares every
// result transaction in order. Sender gaps and receiver stalls vary per phase.
// ----------------------------------------------------------------------------
module supply_voltage_window_protector_tb;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned NUM_PHASES = 5;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam logic [svwp_pkg::CODE_W-1:0] CODE_MAX = '1;

  // tracks protection mode and run counters, holds expected results in order
  class protect_tracker;
    svwp_pkg::cfg_t                cfg;
    svwp_pkg::mode_e               cur_mode;
    logic [svwp_pkg::RUN_W-1:0]    above_run;
    logic [svwp_pkg::RUN_W-1:0]    below_run;
    svwp_pkg::res_t                pending_res[$];
    int unsigned                   mismatches;

    function new();
      cfg.high_trip     = svwp_pkg::HIGH_TRIP_RST;
      cfg.low_trip      = svwp_pkg::LOW_TRIP_RST;
      cfg.high_restart  = svwp_pkg::HIGH_RESTART_RST;
      cfg.low_restart   = svwp_pkg::LOW_RESTART_RST;
      cfg.confirm_count = svwp_pkg::CONFIRM_RST;
      cur_mode   = svwp_pkg::MODE_NORMAL;
      above_run  = '0;
      below_run  = '0;
      mismatches = 0;
    endfunction

    function void apply_reg(logic [svwp_pkg::IDX_W-1:0] idx,
                            logic [svwp_pkg::CODE_W-1:0] data);
      case (idx)
        svwp_pkg::REG_HIGH_TRIP:     cfg.high_trip = data;
        svwp_pkg::REG_LOW_TRIP:      cfg.low_trip = data;
        svwp_pkg::REG_HIGH_RESTART:  cfg.high_restart = data;
        svwp_pkg::REG_LOW_RESTART:   cfg.low_restart = data;
        svwp_pkg::REG_CONFIRM_COUNT: cfg.confirm_count = data[svwp_pkg::RUN_W-1:0];
        default: ;
      endcase
    endfunction

    static function logic [svwp_pkg::RUN_W-1:0] bump_run(
      logic [svwp_pkg::RUN_W-1:0] run, bit hit);
      if (!hit) return '0;
      return (run == svwp_pkg::RUN_MAX) ? svwp_pkg::RUN_MAX : run + 1'b1;
    endfunction

    function void take_sample(logic [svwp_pkg::CODE_W-1:0] code, logic sv);
      svwp_pkg::event_e ev;
      logic [svwp_pkg::RUN_W-1:0] need;
      svwp_pkg::res_t r;
      ev = svwp_pkg::EV_NONE;
      need = (cfg.confirm_count == '0) ? svwp_pkg::RUN_W'(1) : cfg.confirm_count;
      if (sv) begin
        case (cur_mode)
          svwp_pkg::MODE_OFF_HIGH: begin
            below_run = bump_run(below_run, code <= cfg.high_restart);
            above_run = '0;
            if (below_run >= need) begin
              cur_mode  = svwp_pkg::MODE_NORMAL;
              ev        = svwp_pkg::EV_RESTART_HIGH;
              below_run = '0;
            end
          end
          svwp_pkg::MODE_OFF_LOW: begin
            above_run = bump_run(above_run, code >= cfg.low_restart);
            below_run = '0;
            if (above_run >= need) begin
              cur_mode  = svwp_pkg::MODE_NORMAL;
              ev        = svwp_pkg::EV_RESTART_LOW;
              above_run = '0;
            end
          end
          default: begin
            cur_mode  = svwp_pkg::MODE_NORMAL;
            above_run = bump_run(above_run, code >= cfg.high_trip);
            below_run = bump_run(below_run, code <= cfg.low_trip);
            // over-voltage wins when both cut tests are met
            if (above_run >= need) begin
              cur_mode  = svwp_pkg::MODE_OFF_HIGH;
              ev        = svwp_pkg::EV_CUT_HIGH;
              above_run = '0;
              below_run = '0;
            end else if (below_run >= need) begin
              cur_mode  = svwp_pkg::MODE_OFF_LOW;
              ev        = svwp_pkg::EV_CUT_LOW;
              above_run = '0;
              below_run = '0;
            end
          end
        endcase
      end
      r.power_enable = (cur_mode == svwp_pkg::MODE_NORMAL);
      r.mode         = cur_mode;
      r.event_res    = ev;
      pending_res.push_back(r);
    endfunction

    function void check_res(logic pe, svwp_pkg::mode_e md, svwp_pkg::event_e ev);
      svwp_pkg::res_t want;
      if (pending_res.size() == 0) begin
        $error("unexpected result: power_enable %0d mode %0d event_res %0d", pe, md, ev);
        mismatches++;
        return;
      end
      want = pending_res.pop_front();
      if (pe !== want.power_enable) begin
        $error("power_enable: expected %0d, actual %0d", want.power_enable, pe);
        mismatches++;
      end
      if (md !== want.mode) begin
        $error("mode: expected %0d, actual %0d", want.mode, md);
        mismatches++;
      end
      if (ev !== want.event_res) begin
        $error("event_res: expected %0d, actual %0d", want.event_res, ev);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit hold_req;
  protect_tracker tracker = new();

  svwp_sample_if sample_bus ();
  svwp_result_if result_bus ();
  svwp_cfg_if    cfg_bus ();

  supply_voltage_window_protector dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .sample_i (sample_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        result_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (result_bus.valid && result_bus.ready)
        tracker.check_res(result_bus.power_enable, result_bus.mode, result_bus.event_res);
    end
  end

  // pacing knobs change at the rising edge so the negedge processes see them settled
  task automatic set_pacing(int unsigned send_idle, int unsigned stall, bit hold);
    @(posedge clk);
    send_idle_pct = send_idle;
    stall_pct     = stall;
    if (hold) hold_req = 1'b1;
    @(negedge clk);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_sample(logic [svwp_pkg::CODE_W-1:0] code, logic sv);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_bus.valid <= 1'b0;
      @(negedge clk);
    end
    sample_bus.valid        <= 1'b1;
    sample_bus.sample_code  <= code;
    sample_bus.sample_valid <= sv;
    forever begin
      @(posedge clk);
      if (sample_bus.ready) break;
    end
    tracker.take_sample(code, sv);
    @(negedge clk);
  endtask

  // leaves valid high so back-to-back writes need no extra edge
  task automatic write_reg(logic [svwp_pkg::IDX_W-1:0] idx,
                           logic [svwp_pkg::CODE_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    forever begin
      @(posedge clk);
      if (cfg_bus.ready) break;
    end
    tracker.apply_reg(idx, data);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    sample_bus.valid <= 1'b0;
    while (tracker.pending_res.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [svwp_pkg::CODE_W-1:0] near_code(
    logic [svwp_pkg::CODE_W-1:0] thr);
    int t;
    t = int'(thr) + int'($urandom_range(4)) - 2;
    if (t < 0) t = 0;
    if (t > int'(CODE_MAX)) t = int'(CODE_MAX);
    return svwp_pkg::CODE_W'(t);
  endfunction

  function automatic logic [svwp_pkg::CODE_W-1:0] pick_code(int unsigned kind);
    case (kind)
      0: return svwp_pkg::CODE_W'($urandom_range(CODE_MAX, tracker.cfg.high_trip));
      1: return svwp_pkg::CODE_W'($urandom_range(tracker.cfg.low_trip, 0));
      2: return svwp_pkg::CODE_W'($urandom_range(tracker.cfg.high_restart, 0));
      3: return svwp_pkg::CODE_W'($urandom_range(CODE_MAX, tracker.cfg.low_restart));
      4: begin
        case ($urandom_range(3))
          0: return near_code(tracker.cfg.high_trip);
          1: return near_code(tracker.cfg.low_trip);
          2: return near_code(tracker.cfg.high_restart);
          default: return near_code(tracker.cfg.low_restart);
        endcase
      end
      default: return svwp_pkg::CODE_W'($urandom);
    endcase
  endfunction

  // runs of same-region samples so that confirm counts actually get reached
  task automatic run_random(int unsigned n_valid);
    int unsigned sent;
    int unsigned kind;
    int unsigned run_len;
    logic sv;
    sent = 0;
    while (sent < n_valid) begin
      kind    = $urandom_range(5);
      run_len = $urandom_range(tracker.cfg.confirm_count + 3, 1);
      repeat (run_len) begin
        sv = ($urandom_range(9) != 0);
        send_sample(pick_code(kind), sv);
        if (sv) sent++;
      end
    end
  endtask

  task automatic configure_phase(int unsigned p);
    case (p)
      0: begin
        // widest window, confirm of zero acts as one
        write_reg(svwp_pkg::REG_HIGH_TRIP, CODE_MAX);
        write_reg(svwp_pkg::REG_LOW_TRIP, '0);
        write_reg(svwp_pkg::REG_HIGH_RESTART, CODE_MAX);
        write_reg(svwp_pkg::REG_LOW_RESTART, '0);
        write_reg(svwp_pkg::REG_CONFIRM_COUNT, 12'hFF0);
      end
      1: begin
        // overlapping cut thresholds, longest confirm
        write_reg(svwp_pkg::REG_HIGH_TRIP, 12'd1000);
        write_reg(svwp_pkg::REG_LOW_TRIP, 12'd2000);
        write_reg(svwp_pkg::REG_HIGH_RESTART, '0);
        write_reg(svwp_pkg::REG_LOW_RESTART, CODE_MAX);
        write_reg(svwp_pkg::REG_CONFIRM_COUNT, 12'hA5F);
      end
      2: begin
        write_reg(svwp_pkg::REG_HIGH_TRIP, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_LOW_TRIP, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_HIGH_RESTART, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_LOW_RESTART, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_CONFIRM_COUNT, svwp_pkg::CODE_W'($urandom));
        // unused indexes must not disturb anything
        for (int i = int'(svwp_pkg::REG_CONFIRM_COUNT) + 1; i < (1 << svwp_pkg::IDX_W); i++)
          write_reg(svwp_pkg::IDX_W'(i), svwp_pkg::CODE_W'($urandom));
      end
      3: begin
        write_reg(svwp_pkg::REG_HIGH_TRIP, svwp_pkg::HIGH_TRIP_RST);
        write_reg(svwp_pkg::REG_LOW_TRIP, svwp_pkg::LOW_TRIP_RST);
        write_reg(svwp_pkg::REG_HIGH_RESTART, svwp_pkg::HIGH_RESTART_RST);
        write_reg(svwp_pkg::REG_LOW_RESTART, svwp_pkg::LOW_RESTART_RST);
        write_reg(svwp_pkg::REG_CONFIRM_COUNT, 12'd1);
      end
      default: begin
        write_reg(svwp_pkg::REG_HIGH_TRIP,
                  svwp_pkg::CODE_W'($urandom_range(CODE_MAX, 12'd2048)));
        write_reg(svwp_pkg::REG_LOW_TRIP, svwp_pkg::CODE_W'($urandom_range(12'd2047, 0)));
        write_reg(svwp_pkg::REG_HIGH_RESTART, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_LOW_RESTART, svwp_pkg::CODE_W'($urandom));
        write_reg(svwp_pkg::REG_CONFIRM_COUNT, svwp_pkg::CODE_W'($urandom));
      end
    endcase
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    rst_n                   = 1'b0;
    cycle_cnt               = 0;
    send_idle_pct           = 0;
    stall_pct               = 0;
    hold_req                = 1'b0;
    sample_bus.valid        = 1'b0;
    sample_bus.sample_code  = '0;
    sample_bus.sample_valid = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = '0;
    cfg_bus.data            = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed pass at reset thresholds, confirm of three
    send_sample(CODE_MAX, 1'b1);
    send_sample(CODE_MAX, 1'b1);
    send_sample(CODE_MAX, 1'b1);
    send_sample(12'd2000, 1'b0);
    send_sample(12'd1311, 1'b1);
    send_sample(12'd1312, 1'b1);
    send_sample(12'd1311, 1'b1);
    send_sample(12'd1311, 1'b1);
    send_sample(12'd1311, 1'b1);
    send_sample('0, 1'b1);
    send_sample('0, 1'b1);
    send_sample('0, 1'b1);
    send_sample(12'd737, 1'b1);
    send_sample(12'd737, 1'b1);
    send_sample(12'd736, 1'b1);
    send_sample(12'd737, 1'b1);
    send_sample(12'd737, 1'b1);
    send_sample(12'd737, 1'b1);
    send_sample(12'd1352, 1'b1);
    send_sample(12'd1352, 1'b1);
    send_sample(12'd1351, 1'b1);
    send_sample(12'd696, 1'b1);
    send_sample(CODE_MAX, 1'b0);

    for (int unsigned p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      configure_phase(p);
      case (p % 4)
        0: set_pacing(0, 0, 1'b1);
        1: set_pacing(88, 0, 1'b0);
        2: set_pacing(0, 88, 1'b0);
        default: set_pacing(15, 15, 1'b0);
      endcase
      run_random(ITEMS_PER_PHASE);
    end

    sample_bus.valid <= 1'b0;
    while (tracker.pending_res.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/svwp_pkg.sv
rtl/core/svwp_sample_if.sv
rtl/core/svwp_result_if.sv
rtl/core/svwp_cfg_if.sv
rtl/core/svwp_cfg_regs.sv
rtl/core/svwp_core.sv
rtl/core/supply_voltage_window_protector.sv
rtl/core/svwp_checker.sv
tb/sv/supply_voltage_window_protector_tb.sv
